### src/alm_pkg.sv
// Shared types and codes of the array linked list manager.
// Used by the controller, the datapath and the top level; depends on nothing.
package alm_pkg;

    // operation selector carried in each input word
    localparam logic [2:0] F_INS_AFTER  = 3'd0;
    localparam logic [2:0] F_INS_BEFORE = 3'd1;
    localparam logic [2:0] F_DELETE     = 3'd2;
    localparam logic [2:0] F_L2P        = 3'd3;
    localparam logic [2:0] F_P2L        = 3'd4;
    localparam logic [2:0] F_SEARCH     = 3'd5;
    localparam logic [2:0] F_COMPACT    = 3'd6;

    // result status codes
    localparam logic [2:0] ST_OK             = 3'd0;
    localparam logic [2:0] ST_WRONG_POSITION = 3'd1;
    localparam logic [2:0] ST_FULL           = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND      = 3'd3;
    localparam logic [2:0] ST_ORDERED        = 3'd4;

    // datapath micro-operations
    localparam logic [4:0] OP_NONE      = 5'd0;
    localparam logic [4:0] OP_INIT      = 5'd1;
    localparam logic [4:0] OP_LATCH     = 5'd2;
    localparam logic [4:0] OP_RD_POS    = 5'd3;
    localparam logic [4:0] OP_CHK       = 5'd4;
    localparam logic [4:0] OP_RD_FREE   = 5'd5;
    localparam logic [4:0] OP_INS_W1    = 5'd6;
    localparam logic [4:0] OP_INS_W2    = 5'd7;
    localparam logic [4:0] OP_DEL_W1    = 5'd8;
    localparam logic [4:0] OP_DEL_W2    = 5'd9;
    localparam logic [4:0] OP_WALK_INIT = 5'd10;
    localparam logic [4:0] OP_WALK_RD   = 5'd11;
    localparam logic [4:0] OP_WALK_ADV  = 5'd12;
    localparam logic [4:0] OP_PREV_RD   = 5'd13;
    localparam logic [4:0] OP_PREV_ADV  = 5'd14;
    localparam logic [4:0] OP_CP_COPY   = 5'd15;
    localparam logic [4:0] OP_CP_BINIT  = 5'd16;
    localparam logic [4:0] OP_CP_RD     = 5'd17;
    localparam logic [4:0] OP_CP_WR     = 5'd18;
    localparam logic [4:0] OP_CP_FIN    = 5'd19;
    localparam logic [4:0] OP_FIN       = 5'd20;

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] status;
        logic       take_phys;
        logic       take_logic;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       count_zero;
        logic       pos_zero;
        logic       pos_valid;
        logic       free_zero;
        logic       lpos_ok;
        logic       i_eq_lpos;
        logic       i_eq_count;
        logic       s_zero;
        logic       hit;
        logic       ordered;
        logic       c_gt_n;
        logic       c_last;
        logic       out_free;
    } stat_t;

endpackage

### src/alm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module alm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/alm_ctrl.sv
// Sequencer of the array linked list manager: one state per table access step.
// Depends on alm_pkg; drives the datapath through cmd_t, reads stat_t.
module alm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  alm_pkg::stat_t stat,
    output alm_pkg::cmd_t  cmd
);
    import alm_pkg::*;

    localparam logic [4:0] S_INIT = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_DISP = 5'd2;
    localparam logic [4:0] S_I1   = 5'd3;
    localparam logic [4:0] S_I2   = 5'd4;
    localparam logic [4:0] S_I3   = 5'd5;
    localparam logic [4:0] S_I4   = 5'd6;
    localparam logic [4:0] S_X1   = 5'd7;
    localparam logic [4:0] S_X2   = 5'd8;
    localparam logic [4:0] S_X3   = 5'd9;
    localparam logic [4:0] S_L1   = 5'd10;
    localparam logic [4:0] S_L2   = 5'd11;
    localparam logic [4:0] S_R1   = 5'd12;
    localparam logic [4:0] S_R2   = 5'd13;
    localparam logic [4:0] S_R3   = 5'd14;
    localparam logic [4:0] S_S1   = 5'd15;
    localparam logic [4:0] S_S2   = 5'd16;
    localparam logic [4:0] S_C1   = 5'd17;
    localparam logic [4:0] S_C2   = 5'd18;
    localparam logic [4:0] S_C4   = 5'd19;
    localparam logic [4:0] S_C5   = 5'd20;
    localparam logic [4:0] S_C6   = 5'd21;
    localparam logic [4:0] S_FIN  = 5'd22;

    logic [4:0] state_reg, state_next;
    logic [2:0] st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        cmd.op         = OP_NONE;
        cmd.status     = st_reg;
        cmd.take_phys  = 1'b0;
        cmd.take_logic = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op = OP_INIT;
                if (stat.c_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.func)
                    F_INS_AFTER, F_INS_BEFORE:
                    begin
                        cmd.op     = OP_RD_POS;
                        state_next = S_I1;
                    end
                    F_DELETE:
                    begin
                        cmd.op     = OP_RD_POS;
                        state_next = S_X1;
                    end
                    F_P2L:
                    begin
                        cmd.op     = OP_RD_POS;
                        state_next = S_R1;
                    end
                    F_L2P:
                    begin
                        if (!stat.lpos_ok)
                        begin
                            st_next    = ST_WRONG_POSITION;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.op     = OP_WALK_INIT;
                            state_next = S_L1;
                        end
                    end
                    F_SEARCH:
                    begin
                        cmd.op     = OP_WALK_INIT;
                        state_next = S_S1;
                    end
                    F_COMPACT:
                    begin
                        if (stat.ordered)
                        begin
                            st_next    = ST_ORDERED;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.op     = OP_WALK_INIT;
                            state_next = S_C1;
                        end
                    end
                    default:
                    begin
                        st_next    = ST_WRONG_POSITION;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_I1:
            begin
                cmd.op = OP_CHK;
                priority if (stat.count_zero ? !stat.pos_zero : !stat.pos_valid)
                begin
                    st_next    = ST_WRONG_POSITION;
                    state_next = S_FIN;
                end
                else if (stat.free_zero)
                begin
                    st_next    = ST_FULL;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_I2;
                end
            end
            S_I2:
            begin
                cmd.op     = OP_RD_FREE;
                state_next = S_I3;
            end
            S_I3:
            begin
                cmd.op = OP_INS_W1;
                if (stat.count_zero)
                begin
                    st_next    = ST_OK;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_I4;
                end
            end
            S_I4:
            begin
                cmd.op     = OP_INS_W2;
                st_next    = ST_OK;
                state_next = S_FIN;
            end
            S_X1:
            begin
                cmd.op = OP_CHK;
                if (!stat.pos_valid)
                begin
                    st_next    = ST_WRONG_POSITION;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_X2;
                end
            end
            S_X2:
            begin
                cmd.op     = OP_DEL_W1;
                state_next = S_X3;
            end
            S_X3:
            begin
                cmd.op     = OP_DEL_W2;
                st_next    = ST_OK;
                state_next = S_FIN;
            end
            S_L1:
            begin
                if (stat.i_eq_lpos)
                begin
                    cmd.take_phys = 1'b1;
                    st_next       = ST_OK;
                    state_next    = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_WALK_RD;
                    state_next = S_L2;
                end
            end
            S_L2:
            begin
                cmd.op     = OP_WALK_ADV;
                state_next = S_L1;
            end
            S_R1:
            begin
                cmd.op = OP_CHK;
                if (!stat.pos_valid)
                begin
                    st_next    = ST_WRONG_POSITION;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_R2;
                end
            end
            S_R2:
            begin
                if (stat.s_zero)
                begin
                    cmd.take_logic = 1'b1;
                    st_next        = ST_OK;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_PREV_RD;
                    state_next = S_R3;
                end
            end
            S_R3:
            begin
                cmd.op     = OP_PREV_ADV;
                state_next = S_R2;
            end
            S_S1:
            begin
                if (stat.i_eq_count)
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_WALK_RD;
                    state_next = S_S2;
                end
            end
            S_S2:
            begin
                if (stat.hit)
                begin
                    cmd.take_phys  = 1'b1;
                    cmd.take_logic = 1'b1;
                    st_next        = ST_OK;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_WALK_ADV;
                    state_next = S_S1;
                end
            end
            S_C1:
            begin
                if (stat.c_gt_n)
                begin
                    cmd.op     = OP_CP_BINIT;
                    state_next = S_C4;
                end
                else
                begin
                    cmd.op     = OP_WALK_RD;
                    state_next = S_C2;
                end
            end
            S_C2:
            begin
                cmd.op     = OP_CP_COPY;
                state_next = S_C1;
            end
            S_C4:
            begin
                cmd.op     = OP_CP_RD;
                state_next = S_C5;
            end
            S_C5:
            begin
                cmd.op     = OP_CP_WR;
                state_next = stat.c_last ? S_C6 : S_C4;
            end
            S_C6:
            begin
                cmd.op     = OP_CP_FIN;
                st_next    = ST_OK;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_FIN;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/alm_dp.sv
// Datapath of the array linked list manager: link, value and scratch tables,
// list registers, walk counters and the result register. Depends on alm_pkg, alm_ram.
module alm_dp #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [79:0]    in_data,
    input  alm_pkg::cmd_t  cmd,
    output alm_pkg::stat_t stat,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [15:0]    out_data
);
    import alm_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = IW + 1;
    localparam int XW = 13;

    // list registers
    logic [IW-1:0] head_reg, tail_reg, free_reg, count_reg;
    logic          ordered_reg;
    logic [CW-1:0] c_reg;
    logic          out_valid_reg;
    // item and walk registers
    logic [2:0]            func_reg;
    logic [5:0]            pos_reg, lpos_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [IW-1:0]         s_reg, i_reg, pn_reg, pp_reg, n_reg, phys_reg, logic_reg;
    logic [15:0]           out_data_reg;

    // table ports
    logic                  nx_we, pv_we, vl_we, us_we, sc_we;
    logic [IW-1:0]         nx_wa, pv_wa, vl_wa, us_wa, sc_wa;
    logic [IW-1:0]         nx_wd, pv_wd;
    logic [DATA_WIDTH-1:0] vl_wd, sc_wd;
    logic                  us_wd;
    logic [IW-1:0]         nx_ra, pv_ra, vl_ra, us_ra, sc_ra;
    logic [IW-1:0]         rd_next, rd_prev;
    logic [DATA_WIDTH-1:0] rd_val, rd_scr;
    logic                  rd_used;

    logic [IW-1:0] pos_idx, c_idx, c_succ;
    logic          pos_in_range, c_in_list, after;

    assign pos_idx      = IW'(pos_reg);
    assign pos_in_range = XW'(pos_reg) < XW'(CAPACITY);
    assign c_idx        = c_reg[IW-1:0];
    assign c_succ       = c_idx + IW'(1);
    assign c_in_list    = c_reg <= CW'(count_reg);
    assign after        = (func_reg == F_INS_AFTER);

    alm_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(rd_next)
    );
    alm_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(rd_prev)
    );
    alm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_value (
        .clk(clk), .we(vl_we), .waddr(vl_wa), .wdata(vl_wd), .raddr(vl_ra), .rdata(rd_val)
    );
    alm_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_used (
        .clk(clk), .we(us_we), .waddr(us_wa), .wdata(us_wd), .raddr(us_ra), .rdata(rd_used)
    );
    alm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_scratch (
        .clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(sc_wd), .raddr(sc_ra), .rdata(rd_scr)
    );

    always_comb
    begin
        nx_we = 1'b0; nx_wa = c_idx; nx_wd = '0;
        pv_we = 1'b0; pv_wa = c_idx; pv_wd = '0;
        vl_we = 1'b0; vl_wa = c_idx; vl_wd = value_reg;
        us_we = 1'b0; us_wa = c_idx; us_wd = 1'b0;
        sc_we = 1'b0; sc_wa = c_idx; sc_wd = rd_val;
        nx_ra = s_reg; pv_ra = s_reg; vl_ra = s_reg; us_ra = pos_idx; sc_ra = c_idx;
        unique case (cmd.op)
            OP_INIT:
            begin
                nx_we = 1'b1;
                nx_wd = (c_idx == '0 || c_reg == CW'(CAPACITY - 1)) ? '0 : c_succ;
                us_we = 1'b1;
            end
            OP_RD_POS:
            begin
                nx_ra = pos_idx;
                pv_ra = pos_idx;
            end
            OP_RD_FREE:
            begin
                nx_ra = free_reg;
            end
            OP_INS_W1:
            begin
                nx_we = 1'b1; nx_wa = free_reg;
                pv_we = 1'b1; pv_wa = free_reg;
                vl_we = 1'b1; vl_wa = free_reg;
                us_we = 1'b1; us_wa = free_reg; us_wd = 1'b1;
                priority if (count_reg == '0)
                begin
                    nx_wd = '0;
                    pv_wd = '0;
                end
                else if (after)
                begin
                    nx_wd = pn_reg;
                    pv_wd = pos_idx;
                end
                else
                begin
                    nx_wd = pos_idx;
                    pv_wd = pp_reg;
                end
            end
            OP_INS_W2:
            begin
                nx_wd = n_reg;
                pv_wd = n_reg;
                if (after)
                begin
                    nx_we = 1'b1; nx_wa = pos_idx;
                    pv_we = (pos_idx != tail_reg); pv_wa = pn_reg;
                end
                else
                begin
                    pv_we = 1'b1; pv_wa = pos_idx;
                    nx_we = (pos_idx != head_reg); nx_wa = pp_reg;
                end
            end
            OP_DEL_W1:
            begin
                nx_we = (pos_idx != head_reg); nx_wa = pp_reg; nx_wd = pn_reg;
                pv_we = (pos_idx != tail_reg); pv_wa = pn_reg; pv_wd = pp_reg;
                us_we = 1'b1; us_wa = pos_idx;
            end
            OP_DEL_W2:
            begin
                nx_we = 1'b1; nx_wa = pos_idx; nx_wd = free_reg;
            end
            OP_CP_COPY:
            begin
                sc_we = 1'b1;
            end
            OP_CP_WR:
            begin
                nx_we = 1'b1;
                if (c_in_list)
                begin
                    nx_wd = (c_reg == CW'(count_reg)) ? '0 : c_succ;
                end
                else
                begin
                    nx_wd = (c_reg == CW'(CAPACITY - 1)) ? '0 : c_succ;
                end
                pv_we = c_in_list; pv_wd = c_idx - IW'(1);
                vl_we = c_in_list; vl_wd = rd_scr;
                us_we = 1'b1; us_wd = c_in_list;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= IW'(1);
            count_reg     <= '0;
            ordered_reg   <= 1'b1;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_FIN)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_INIT:
                begin
                    c_reg <= c_reg + CW'(1);
                end
                OP_INS_W1:
                begin
                    free_reg  <= rd_next;
                    count_reg <= count_reg + IW'(1);
                    if (count_reg == '0)
                    begin
                        head_reg    <= free_reg;
                        tail_reg    <= free_reg;
                        ordered_reg <= 1'b1;
                    end
                end
                OP_INS_W2:
                begin
                    if (after)
                    begin
                        if (pos_idx == tail_reg)
                        begin
                            tail_reg <= n_reg;
                        end
                        else
                        begin
                            ordered_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        ordered_reg <= 1'b0;
                        if (pos_idx == head_reg)
                        begin
                            head_reg <= n_reg;
                        end
                    end
                end
                OP_DEL_W1:
                begin
                    if (pos_idx == head_reg)
                    begin
                        head_reg <= pn_reg;
                    end
                    if (pos_idx == tail_reg)
                    begin
                        tail_reg <= pp_reg;
                    end
                    else
                    begin
                        ordered_reg <= 1'b0;
                    end
                end
                OP_DEL_W2:
                begin
                    free_reg  <= pos_idx;
                    count_reg <= count_reg - IW'(1);
                    // list becomes empty
                    if (count_reg == IW'(1))
                    begin
                        head_reg    <= '0;
                        tail_reg    <= '0;
                        ordered_reg <= 1'b1;
                    end
                end
                OP_WALK_INIT, OP_CP_BINIT:
                begin
                    c_reg <= CW'(1);
                end
                OP_CP_COPY, OP_CP_WR:
                begin
                    c_reg <= c_reg + CW'(1);
                end
                OP_CP_FIN:
                begin
                    head_reg    <= (count_reg != '0) ? IW'(1) : '0;
                    tail_reg    <= count_reg;
                    free_reg    <= (CW'(count_reg) + CW'(1) < CW'(CAPACITY))
                                   ? count_reg + IW'(1) : '0;
                    ordered_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // item, walk and result payload
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LATCH:
            begin
                func_reg  <= in_data[2:0];
                pos_reg   <= in_data[8:3];
                lpos_reg  <= in_data[14:9];
                value_reg <= in_data[15 +: DATA_WIDTH];
                phys_reg  <= '0;
                logic_reg <= '0;
            end
            OP_CHK:
            begin
                pn_reg <= rd_next;
                pp_reg <= rd_prev;
                s_reg  <= rd_prev;
                i_reg  <= '0;
            end
            OP_INS_W1:
            begin
                n_reg    <= free_reg;
                phys_reg <= free_reg;
            end
            OP_WALK_INIT:
            begin
                s_reg <= head_reg;
                i_reg <= '0;
            end
            OP_WALK_ADV, OP_CP_COPY:
            begin
                s_reg <= rd_next;
                i_reg <= i_reg + IW'(1);
            end
            OP_PREV_RD:
            begin
                i_reg <= i_reg + IW'(1);
            end
            OP_PREV_ADV:
            begin
                s_reg <= rd_prev;
            end
            OP_FIN:
            begin
                out_data_reg <= {1'b0, 6'(logic_reg), 6'(phys_reg), cmd.status};
            end
            default:
            begin
            end
        endcase
        if (cmd.take_phys)
        begin
            phys_reg <= s_reg;
        end
        if (cmd.take_logic)
        begin
            logic_reg <= i_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stat.func       = func_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.pos_zero   = (pos_reg == '0);
    assign stat.pos_valid  = (pos_reg != '0) && pos_in_range && rd_used;
    assign stat.free_zero  = (free_reg == '0);
    assign stat.lpos_ok    = XW'(lpos_reg) < XW'(count_reg);
    assign stat.i_eq_lpos  = XW'(i_reg) == XW'(lpos_reg);
    assign stat.i_eq_count = (i_reg == count_reg);
    assign stat.s_zero     = (s_reg == '0);
    assign stat.hit        = (rd_val == value_reg);
    assign stat.ordered    = ordered_reg;
    assign stat.c_gt_n     = c_reg > CW'(count_reg);
    assign stat.c_last     = (c_reg == CW'(CAPACITY - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

### src/array_linked_list_manager_unit.sv
// Top level of the array linked list manager: controller plus datapath.
// Depends on alm_pkg, alm_ctrl, alm_dp (and alm_ram through the datapath).
//
// A doubly linked list kept in a table of CAPACITY slots, slot 0 a sentinel.
// Each word on the s_axis channel names one operation (insert after/before,
// delete, index mapping either way, search, compact); each yields one result
// word on the m_axis channel with a status and two indices.
// One item is in work at a time. The link walk makes one table read and one
// pointer update per step, through the registered read port of the link memory.
// Index mapping, search and compact walk the list link by link; compact then
// rewrites every slot of the table in order.
// After reset a clearing pass rebuilds the free chain; s_axis_tready stays
// low until it is done.
// The result sits in an output register; a stalled receiver holds it, and
// the block still takes and works the next item, waiting only to deliver.
module array_linked_list_manager_unit #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[2:0], position[8:3], logic_position[14:9], value[78:15], zero pad
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], slot[8:3], list position[14:9], zero pad
    output logic [15:0] m_axis_tdata
);
    import alm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    alm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    alm_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
